// ----- hw/rtl/gtzr_pkg.sv -----
// ============================================================================
// gtzr_pkg: shared types and constants of the triangle raster core
// Field widths, action and register codes, sequencer states and job codes.
// ============================================================================
package gtzr_pkg;

  // Default sizes of the pixel stores.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int DEPTH_BITS_DEF = 16;

  // Field widths of the channels.
  localparam int ACT_W   = 2;
  localparam int COORD_W = 11;
  localparam int Z_W     = 16;
  localparam int SHADE_W = 9;
  localparam int RGB_W   = 24;
  localparam int CNT_W   = 17;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd3;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_VERTEX = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  // Largest channel value after shading.
  localparam int CHANNEL_MAX = 255;

  // Quotient bits produced by the shared divider.
  localparam int DIV_W = 31;

  // One vertex as held between items.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [Z_W-1:0]     z;
    logic [SHADE_W-1:0]        s;
  } vtx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FIN, S_RDA, S_RDB, S_SORT, S_ROW, S_MUL,
    S_DIVS, S_DIV, S_JOBEND, S_SPAN, S_PIX, S_PXRD, S_CMP, S_WR
  } st_t;

  // Jobs of the shared multiply and divide unit.
  typedef enum logic [3:0] {
    J_AX, J_AZ, J_AS, J_BX, J_BZ, J_BS, J_PZ, J_PS, J_CR, J_CG, J_CB
  } job_t;

endpackage

// ----- hw/rtl/gtzr_if.sv -----
// ============================================================================
// gtzr_if: item channels of the triangle raster core
// Input channel carries actions and vertices, output channel carries results.
// ============================================================================
interface gtzr_in_if;
  import gtzr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic signed [Z_W-1:0]     vertex_z;
  logic [SHADE_W-1:0]        vertex_shade;
  logic [RGB_W-1:0]          vertex_color;

  modport source (output valid, action, vertex_x, vertex_y, vertex_z, vertex_shade,
                  vertex_color, input ready);
  modport sink (input valid, action, vertex_x, vertex_y, vertex_z, vertex_shade,
                vertex_color, output ready);
endinterface

interface gtzr_out_if;
  import gtzr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [RGB_W-1:0]      pixel_color;
  logic signed [Z_W-1:0] pixel_depth;
  logic [CNT_W-1:0]      pixels_written;
  logic                  triangle_dropped;

  modport source (output valid, pixel_color, pixel_depth, pixels_written,
                  triangle_dropped, input ready);
  modport sink (input valid, pixel_color, pixel_depth, pixels_written,
                triangle_dropped, output ready);
endinterface

// ----- hw/rtl/gouraud_triangle_zbuffer_raster_core.sv -----
// ============================================================================
// gouraud_triangle_zbuffer_raster_core: scanline rasterizer with depth test
// Collects vertices, scans shaded triangles into color and depth stores,
// and serves clear and read actions.
// ============================================================================
//
//  Channel   Dir   Handshake     Carries
//  -------   ---   -----------   ------------------------------------------
//  in_ch     in    valid/ready   action, vertex x/y/z, shade, color
//  out_ch    out   valid/ready   pixel color/depth, pixels written, dropped
//  cfg_*     in    write enable  screen size, guard margin, background color
//
//  Held vertices, dropped triangles and out-of-area reads load their result
//  straight into the output register; an in-area read passes S_RDA, S_RDB
//  and S_FIN. A clear, and the pass that follows reset, sweeps both stores
//  one entry a cycle over all MAX_WIDTH*MAX_HEIGHT entries (65536). A drawn
//  triangle is scanned row by row; each interpolated value is one job of the
//  shared multiplier and bit-serial divider. Input is taken only when idle,
//  and only once the output register is empty or its result is being taken.
//
module gouraud_triangle_zbuffer_raster_core #(
  parameter int MAX_WIDTH  = gtzr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gtzr_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = gtzr_pkg::DEPTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gtzr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gtzr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  gtzr_in_if.sink                         in_ch,
  gtzr_out_if.source                      out_ch
);
  import gtzr_pkg::*;

  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = $clog2(NPIX);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NPIX - 1);
  localparam logic signed [32:0] DMAX = (33'sd1 <<< (DEPTH_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] DMIN = -(33'sd1 <<< (DEPTH_BITS - 1));
  localparam logic [DEPTH_BITS-1:0] DEPTH_CLR = DEPTH_BITS'(DMIN);
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // Configuration registers.
  logic [8:0]  sw_r, sh_r;
  logic [7:0]  gm_r;
  logic [23:0] bg_r;

  // Control state.
  st_t             st_r, st_nxt;
  logic [1:0]      vcnt_r;
  vtx_t            held0_r, held1_r;
  logic            out_valid_r;
  logic [AW-1:0]   clr_addr_r;
  logic            clr_resp_r;
  logic [23:0]     clr_color_r;

  // Datapath registers.
  vtx_t                   v0_r, v1_r, v2_r;
  logic [23:0]            rgb_r;
  logic signed [11:0]     total_r, h1_r, i_r, j_r, hi_r, span_r;
  logic [YW-1:0]          y_r;
  logic signed [19:0]     ax_r, az_r, as_r, bx_r, bz_r, bs_r, pz_r, ps_r;
  logic [DEPTH_BITS-1:0]  pzs_r;
  logic [23:0]            col_r;
  logic [CNT_W-1:0]       count_r;
  job_t                   job_r;
  logic signed [29:0]     prod_r;
  logic [DIV_W-1:0]       num_r;
  logic [11:0]            rem_r, den2_r;
  logic                   neg_r;
  logic [4:0]             dcnt_r;
  logic [AW-1:0]          rd_addr_r;
  logic [RGB_W-1:0]       res_color_r;
  logic [Z_W-1:0]         res_depth_r;
  logic [RGB_W-1:0]       out_color_r;
  logic [Z_W-1:0]         out_depth_r;
  logic [CNT_W-1:0]       out_cnt_r;
  logic                   out_drop_r;

  // Memories with registered read data.
  logic [DEPTH_BITS-1:0]  depth_mem [NPIX];
  logic [23:0]            color_mem [NPIX];
  logic [DEPTH_BITS-1:0]  rd_depth_r;
  logic [23:0]            rd_color_r;

  // Effective clip sizes.
  logic [10:0] w_eff, h_eff;
  assign w_eff = (11'(sw_r) < 11'(MAX_WIDTH)) ? 11'(sw_r) : 11'(MAX_WIDTH);
  assign h_eff = (11'(sh_r) < 11'(MAX_HEIGHT)) ? 11'(sh_r) : 11'(MAX_HEIGHT);

  // Incoming vertex and handshake.
  vtx_t in_v;
  logic in_acc, in_ready;
  assign in_v = {in_ch.vertex_x, in_ch.vertex_y, in_ch.vertex_z, in_ch.vertex_shade};
  assign in_ready     = (st_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = in_ready;
  assign in_acc       = in_ch.valid && in_ready;

  // Guard band test for one vertex.
  function automatic logic vis(vtx_t v, logic [7:0] g, logic [8:0] sw, logic [8:0] sh);
    logic signed [12:0] lo, hx, hy;
    lo = -$signed({5'd0, g});
    hx = $signed({4'd0, sw}) + $signed({5'd0, g});
    hy = $signed({4'd0, sh}) + $signed({5'd0, g});
    return (13'(v.x) >= lo) && (13'(v.x) <= hx) && (13'(v.y) >= lo) && (13'(v.y) <= hy);
  endfunction

  // Triangle drop decision and read range check at accept time.
  logic tri_drop, rd_in;
  always_comb begin
    tri_drop = !vis(held0_r, gm_r, sw_r, sh_r) || !vis(held1_r, gm_r, sw_r, sh_r) ||
               !vis(in_v, gm_r, sw_r, sh_r) ||
               ((held0_r.y == held1_r.y) && (held0_r.y == in_v.y));
    rd_in    = (in_v.x >= 11'sd0) && (in_v.x < $signed(w_eff)) &&
               (in_v.y >= 11'sd0) && (in_v.y < $signed(h_eff));
  end

  // Sort network by y.
  vtx_t s0, s1, s2, tv;
  always_comb begin
    s0 = v0_r; s1 = v1_r; s2 = v2_r;
    if (s0.y > s1.y) begin tv = s0; s0 = s1; s1 = tv; end
    if (s0.y > s2.y) begin tv = s0; s0 = s2; s2 = tv; end
    if (s1.y > s2.y) begin tv = s1; s1 = s2; s2 = tv; end
    tv = s0;
  end

  // Row geometry: which edge pair is active.
  logic               second;
  logic signed [11:0] seg, kk, row_y;
  vtx_t               pp, qq;
  always_comb begin
    second = (i_r > h1_r) || (h1_r == 12'sd0);
    seg    = second ? (12'(v2_r.y) - 12'(v1_r.y)) : h1_r;
    kk     = second ? (i_r - h1_r) : i_r;
    pp     = second ? v1_r : v0_r;
    qq     = second ? v2_r : v1_r;
    row_y  = 12'(v0_r.y) + i_r;
  end

  // Operand selection of the shared unit.
  logic signed [17:0] ma;
  logic signed [11:0] mb, den;
  logic signed [19:0] base;
  always_comb begin
    ma = '0; mb = '0; den = 12'sd1; base = '0;
    case (job_r)
      J_AX: begin
        ma = 18'(v2_r.x) - 18'(v0_r.x); mb = i_r; den = total_r; base = 20'(v0_r.x);
      end
      J_AZ: begin
        ma = 18'(v2_r.z) - 18'(v0_r.z); mb = i_r; den = total_r; base = 20'(v0_r.z);
      end
      J_AS: begin
        ma = ($signed({9'd0, v2_r.s}) - $signed({9'd0, v0_r.s})) <<< 8;
        mb = i_r; den = total_r; base = $signed({3'd0, v0_r.s, 8'd0});
      end
      J_BX: begin
        ma = 18'(qq.x) - 18'(pp.x); mb = kk; den = seg; base = 20'(pp.x);
      end
      J_BZ: begin
        ma = 18'(qq.z) - 18'(pp.z); mb = kk; den = seg; base = 20'(pp.z);
      end
      J_BS: begin
        ma = ($signed({9'd0, qq.s}) - $signed({9'd0, pp.s})) <<< 8;
        mb = kk; den = seg; base = $signed({3'd0, pp.s, 8'd0});
      end
      J_PZ: begin
        ma = 18'(bz_r - az_r); mb = j_r - 12'(ax_r); den = span_r; base = az_r;
      end
      J_PS: begin
        ma = 18'(bs_r - as_r); mb = j_r - 12'(ax_r); den = span_r; base = as_r;
      end
      J_CR: begin ma = 18'(ps_r); mb = $signed({4'd0, rgb_r[7:0]}); end
      J_CG: begin ma = 18'(ps_r); mb = $signed({4'd0, rgb_r[15:8]}); end
      J_CB: begin ma = 18'(ps_r); mb = $signed({4'd0, rgb_r[23:16]}); end
      default: begin ma = '0; end
    endcase
  end

  // Divider setup, step and final result.
  logic signed [31:0] nn;
  logic [12:0]        trial;
  logic               qbit;
  logic [19:0]        qv;
  logic signed [19:0] jres;
  logic signed [13:0] chv;
  logic [7:0]         chan;
  always_comb begin
    nn    = $signed({prod_r[29], prod_r, 1'b0}) + 32'(den);
    trial = {rem_r, num_r[DIV_W-1]};
    qbit  = trial >= {1'b0, den2_r};
    qv    = neg_r ? ~num_r[19:0] : num_r[19:0];
    jres  = base + $signed(qv);
    chv   = 14'(prod_r >>> 16);
    if (chv > 14'sd255)     chan = 8'(CHANNEL_MAX);
    else if (chv < 14'sd0)  chan = 8'd0;
    else                    chan = chv[7:0];
  end

  // Span setup after ordering the two ends.
  logic               swp;
  logic signed [19:0] nax, nbx, nlo, nhi, wm1;
  always_comb begin
    swp = ax_r > bx_r;
    nax = swp ? bx_r : ax_r;
    nbx = swp ? ax_r : bx_r;
    wm1 = $signed({9'd0, w_eff}) - 20'sd1;
    nlo = (nax < 20'sd0) ? 20'sd0 : nax;
    nhi = (nbx < wm1) ? nbx : wm1;
  end

  // Depth saturation and pixel address.
  logic signed [32:0]    pz33;
  logic [DEPTH_BITS-1:0] pz_sat;
  logic [AW-1:0]         pix_addr;
  always_comb begin
    pz33 = 33'(pz_r);
    if (pz33 > DMAX)      pz_sat = DEPTH_BITS'(DMAX);
    else if (pz33 < DMIN) pz_sat = DEPTH_BITS'(DMIN);
    else                  pz_sat = DEPTH_BITS'(pz33);
    pix_addr = AW'(y_r) * AW'(MAX_WIDTH) + AW'(j_r[XW-1:0]);
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLEAR:  if (clr_addr_r == LAST_ADDR) st_nxt = clr_resp_r ? S_FIN : S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.action)
            ACT_CLEAR:  st_nxt = S_CLEAR;
            ACT_VERTEX: if (vcnt_r == 2'd2 && !tri_drop) st_nxt = S_SORT;
            ACT_READ:   if (rd_in) st_nxt = S_RDA;
            default:    st_nxt = S_IDLE;
          endcase
        end
      end
      S_FIN:    if (!out_valid_r || out_ch.ready) st_nxt = S_IDLE;
      S_RDA:    st_nxt = S_RDB;
      S_RDB:    st_nxt = S_FIN;
      S_SORT:   st_nxt = S_ROW;
      S_ROW: begin
        if (i_r == total_r) st_nxt = S_FIN;
        else if (row_y >= 12'sd0 && row_y < $signed({1'b0, h_eff})) st_nxt = S_MUL;
      end
      S_MUL: begin
        if (job_r == J_CR || job_r == J_CG || job_r == J_CB) st_nxt = S_JOBEND;
        else st_nxt = S_DIVS;
      end
      S_DIVS:   st_nxt = S_DIV;
      S_DIV:    if (dcnt_r == 5'(DIV_W - 1)) st_nxt = S_JOBEND;
      S_JOBEND: begin
        case (job_r)
          J_BS:    st_nxt = S_SPAN;
          J_PS:    st_nxt = S_PXRD;
          J_CB:    st_nxt = S_WR;
          default: st_nxt = S_MUL;
        endcase
      end
      S_SPAN:   st_nxt = S_PIX;
      S_PIX: begin
        if (j_r > hi_r) st_nxt = S_ROW;
        else if (span_r == 12'sd0) st_nxt = S_PXRD;
        else st_nxt = S_MUL;
      end
      S_PXRD:   st_nxt = S_CMP;
      S_CMP:    st_nxt = ($signed(rd_depth_r) < $signed(pzs_r)) ? S_MUL : S_PIX;
      S_WR:     st_nxt = S_PIX;
      default:  st_nxt = S_IDLE;
    endcase
  end

  // Memory and output register controls.
  logic                  mem_re, mem_we, imm_load, fin_load;
  logic [AW-1:0]         mem_raddr, mem_waddr;
  logic [DEPTH_BITS-1:0] mem_wdepth;
  logic [23:0]           mem_wcolor;
  always_comb begin
    mem_re     = (st_r == S_RDA) || (st_r == S_PXRD);
    mem_raddr  = (st_r == S_RDA) ? rd_addr_r : pix_addr;
    mem_we     = (st_r == S_CLEAR) || (st_r == S_WR);
    mem_waddr  = (st_r == S_CLEAR) ? clr_addr_r : pix_addr;
    mem_wdepth = (st_r == S_CLEAR) ? DEPTH_CLR : pzs_r;
    mem_wcolor = (st_r == S_CLEAR) ? clr_color_r : col_r;
    imm_load   = in_acc && (st_nxt == S_IDLE);
    fin_load   = (st_r == S_FIN) && (!out_valid_r || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[mem_waddr] <= mem_wdepth;
      color_mem[mem_waddr] <= mem_wcolor;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_depth_r <= depth_mem[mem_raddr];
      rd_color_r <= color_mem[mem_raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      sw_r        <= 9'd256;
      sh_r        <= 9'd256;
      gm_r        <= 8'd0;
      bg_r        <= 24'd0;
      vcnt_r      <= 2'd0;
      held0_r     <= '0;
      held1_r     <= '0;
      out_valid_r <= 1'b0;
      clr_addr_r  <= '0;
      clr_resp_r  <= 1'b0;
      clr_color_r <= 24'd0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SCREEN_W: sw_r <= cfg_wdata[8:0];
          CFG_SCREEN_H: sh_r <= cfg_wdata[8:0];
          CFG_GUARD:    gm_r <= cfg_wdata[7:0];
          CFG_BG_COLOR: bg_r <= cfg_wdata;
          default:      gm_r <= gm_r;
        endcase
      end
      if (st_r == S_CLEAR) clr_addr_r <= clr_addr_r + AW'(1);
      if (in_acc && in_ch.action == ACT_CLEAR) begin
        clr_addr_r  <= '0;
        clr_resp_r  <= 1'b1;
        clr_color_r <= bg_r;
      end
      if (in_acc && in_ch.action == ACT_VERTEX) begin
        if (vcnt_r == 2'd0)      begin held0_r <= in_v; vcnt_r <= 2'd1; end
        else if (vcnt_r == 2'd1) begin held1_r <= in_v; vcnt_r <= 2'd2; end
        else                     vcnt_r <= 2'd0;
      end
      if (imm_load || fin_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready)             out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (imm_load) begin
      out_color_r <= '0;
      out_depth_r <= '0;
      out_cnt_r   <= '0;
      out_drop_r  <= (in_ch.action == ACT_VERTEX) && (vcnt_r == 2'd2);
    end else if (fin_load) begin
      out_color_r <= res_color_r;
      out_depth_r <= res_depth_r;
      out_cnt_r   <= count_r;
      out_drop_r  <= 1'b0;
    end
    case (st_r)
      S_IDLE: begin
        res_color_r <= '0;
        res_depth_r <= '0;
        count_r     <= '0;
        rd_addr_r   <= AW'(in_v.y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(in_v.x[XW-1:0]);
        v0_r  <= held0_r;
        v1_r  <= held1_r;
        v2_r  <= in_v;
        rgb_r <= in_ch.vertex_color;
      end
      S_RDB: begin
        res_color_r <= rd_color_r;
        res_depth_r <= 16'(32'($signed(rd_depth_r)));
      end
      S_SORT: begin
        v0_r    <= s0;
        v1_r    <= s1;
        v2_r    <= s2;
        total_r <= 12'(s2.y) - 12'(s0.y);
        h1_r    <= 12'(s1.y) - 12'(s0.y);
        i_r     <= '0;
      end
      S_ROW: begin
        y_r   <= row_y[YW-1:0];
        job_r <= J_AX;
        if (!(row_y >= 12'sd0 && row_y < $signed({1'b0, h_eff}))) i_r <= i_r + 12'sd1;
      end
      S_MUL:  prod_r <= 30'(ma) * 30'(mb);
      S_DIVS: begin
        neg_r  <= nn[31];
        num_r  <= nn[31] ? ~nn[DIV_W-1:0] : nn[DIV_W-1:0];
        den2_r <= {den[10:0], 1'b0};
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      S_DIV: begin
        rem_r  <= qbit ? 12'(trial - {1'b0, den2_r}) : trial[11:0];
        num_r  <= {num_r[DIV_W-2:0], qbit};
        dcnt_r <= dcnt_r + 5'd1;
      end
      S_JOBEND: begin
        case (job_r)
          J_AX: begin ax_r <= jres; job_r <= J_AZ; end
          J_AZ: begin az_r <= jres; job_r <= J_AS; end
          J_AS: begin as_r <= jres; job_r <= J_BX; end
          J_BX: begin bx_r <= jres; job_r <= J_BZ; end
          J_BZ: begin bz_r <= jres; job_r <= J_BS; end
          J_BS: bs_r <= jres;
          J_PZ: begin pz_r <= jres; job_r <= J_PS; end
          J_PS: ps_r <= jres;
          J_CR: begin col_r[7:0]   <= chan; job_r <= J_CG; end
          J_CG: begin col_r[15:8]  <= chan; job_r <= J_CB; end
          J_CB: col_r[23:16] <= chan;
          default: job_r <= J_AX;
        endcase
      end
      S_SPAN: begin
        ax_r   <= nax;
        bx_r   <= nbx;
        az_r   <= swp ? bz_r : az_r;
        bz_r   <= swp ? az_r : bz_r;
        as_r   <= swp ? bs_r : as_r;
        bs_r   <= swp ? as_r : bs_r;
        span_r <= 12'(nbx - nax);
        j_r    <= 12'(nlo);
        hi_r   <= 12'(nhi);
      end
      S_PIX: begin
        job_r <= J_PZ;
        if (j_r > hi_r) i_r <= i_r + 12'sd1;
        if (span_r == 12'sd0) begin
          pz_r <= bz_r;
          ps_r <= bs_r;
        end
      end
      S_PXRD: pzs_r <= pz_sat;
      S_CMP: begin
        job_r <= J_CR;
        if (!($signed(rd_depth_r) < $signed(pzs_r))) j_r <= j_r + 12'sd1;
      end
      S_WR: begin
        j_r <= j_r + 12'sd1;
        if (count_r != CNT_SAT) count_r <= count_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Result channel.
  assign out_ch.valid            = out_valid_r;
  assign out_ch.pixel_color      = out_color_r;
  assign out_ch.pixel_depth      = $signed(out_depth_r);
  assign out_ch.pixels_written   = out_cnt_r;
  assign out_ch.triangle_dropped = out_drop_r;

  // An accepted item always finds room for its result.
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!out_valid_r || out_ch.ready))
    else $error("item accepted while the result register is blocked");

  // The divider never starts on a zero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIVS) |-> (den != 12'sd0))
    else $error("divide job with zero denominator");

  // Stores are written only by the clearing pass or a pixel that won the test.
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (st_r == S_CLEAR || st_r == S_WR))
    else $error("store write outside clear or pixel write");

  // A pixel write is always nearer than what the store held.
  a_depth_win: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WR) |-> ($signed(rd_depth_r) < $signed(pzs_r)))
    else $error("pixel written without passing the depth test");

endmodule
